/* rtl/msq_pkg.sv */
// Shared types, constants and lookup functions for the marching-squares cell block.
// Used by every module under rtl; depends on nothing else.
package msq_pkg;

  localparam int H_W           = 16;
  localparam int IDX_W         = 10;
  localparam int COORD_W       = 18;
  localparam int DIV_W         = 17;
  localparam int CODE_W        = 4;
  localparam int QUEUE_DEPTH   = 4;
  localparam int GRID_DIM_DEF  = 1024;
  localparam int FRAC_BITS_DEF = 8;
  localparam int IN_W          = 88;
  localparam int OUT_W         = 72;
  localparam int USER_W        = 5;

  localparam logic [CODE_W-1:0] CASE_NONE     = 4'd0;
  localparam logic [CODE_W-1:0] CASE_SADDLE_A = 4'd5;
  localparam logic [CODE_W-1:0] CASE_SADDLE_B = 4'd10;
  localparam logic [CODE_W-1:0] CASE_ALL      = 4'd15;

  typedef enum logic [1:0] {
    EDGE_L = 2'd0,
    EDGE_R = 2'd1,
    EDGE_T = 2'd2,
    EDGE_B = 2'd3
  } edge_t;

  typedef struct packed {
    logic [3:0][DIV_W-1:0] num;
    logic [3:0][DIV_W-1:0] den;
    logic [CODE_W-1:0]     code;
    logic                  flip;
    logic [IDX_W-1:0]      row;
    logic [IDX_W-1:0]      col;
  } cell_t;

  function automatic edge_t seg_first(input logic [CODE_W-1:0] code);
    edge_t e;
    case (code)
      4'd1, 4'd3, 4'd7:        e = EDGE_L;
      4'd2, 4'd6, 4'd14:       e = EDGE_B;
      4'd4, 4'd12, 4'd13:      e = EDGE_R;
      default:                 e = EDGE_T;
    endcase
    return e;
  endfunction

  function automatic edge_t seg_second(input logic [CODE_W-1:0] code);
    edge_t e;
    case (code)
      4'd1, 4'd9, 4'd13:       e = EDGE_B;
      4'd2, 4'd3, 4'd11:       e = EDGE_R;
      4'd8, 4'd12, 4'd14:      e = EDGE_L;
      default:                 e = EDGE_T;
    endcase
    return e;
  endfunction

  // Returns {numerator, denominator} with the denominator made positive.
  // A crossing that starts on the isoline, or a flat edge, maps to 0 / 1.
  function automatic logic [2*DIV_W-1:0] edge_ratio(input logic signed [H_W-1:0] iso,
                                                    input logic signed [H_W-1:0] za,
                                                    input logic signed [H_W-1:0] zb);
    logic signed [DIV_W:0] num;
    logic signed [DIV_W:0] den;
    logic [2*DIV_W-1:0]    res;
    num = (DIV_W+1)'(iso) - (DIV_W+1)'(za);
    den = (DIV_W+1)'(zb) - (DIV_W+1)'(za);
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (den == 0 || num <= 0) begin
      res = {DIV_W'(0), DIV_W'(1)};
    end else begin
      res = {num[DIV_W-1:0], den[DIV_W-1:0]};
    end
    return res;
  endfunction

endpackage

/* rtl/msq_front.sv */
// Front end: holds the isoline register, classifies each cell and forms the
// division operands of the left, right, top and bottom edges. Depends on msq_pkg.
module msq_front import msq_pkg::*; #(
  parameter int GRID_DIM = GRID_DIM_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [H_W-1:0]    cfg_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,
  output logic              push_valid,
  input  logic              push_ready,
  output cell_t             push_item
);

  logic signed [H_W-1:0]   isoline;
  logic signed [H_W-1:0]   z_tl, z_tr, z_br, z_bl;
  logic [IDX_W-1:0]        row, col;
  logic [CODE_W-1:0]       code;
  logic signed [H_W+2:0]   zsum;
  logic signed [H_W+2:0]   iso4;
  logic                    inside_grid;
  logic [2*DIV_W-1:0]      r_l, r_r, r_t, r_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      isoline <= '0;
    end else if (cfg_valid) begin
      isoline <= cfg_data;
    end
  end

  assign z_tl = s_tdata[15:0];
  assign z_tr = s_tdata[31:16];
  assign z_br = s_tdata[47:32];
  assign z_bl = s_tdata[63:48];
  assign row  = s_tdata[73:64];
  assign col  = s_tdata[83:74];

  always_comb begin
    code = {z_tl >= isoline, z_tr >= isoline, z_br >= isoline, z_bl >= isoline};
    zsum = (H_W+3)'(z_tl) + (H_W+3)'(z_tr) + (H_W+3)'(z_br) + (H_W+3)'(z_bl);
    iso4 = (H_W+3)'(isoline) <<< 2;
    inside_grid = (32'(row) <= 32'(GRID_DIM - 2)) && (32'(col) <= 32'(GRID_DIM - 2));
    r_l = edge_ratio(isoline, z_tl, z_bl);
    r_r = edge_ratio(isoline, z_tr, z_br);
    r_t = edge_ratio(isoline, z_tl, z_tr);
    r_b = edge_ratio(isoline, z_bl, z_br);
    push_item.num[EDGE_L] = r_l[2*DIV_W-1:DIV_W];
    push_item.den[EDGE_L] = r_l[DIV_W-1:0];
    push_item.num[EDGE_R] = r_r[2*DIV_W-1:DIV_W];
    push_item.den[EDGE_R] = r_r[DIV_W-1:0];
    push_item.num[EDGE_T] = r_t[2*DIV_W-1:DIV_W];
    push_item.den[EDGE_T] = r_t[DIV_W-1:0];
    push_item.num[EDGE_B] = r_b[2*DIV_W-1:DIV_W];
    push_item.den[EDGE_B] = r_b[DIV_W-1:0];
    push_item.code = code;
    push_item.flip = (code == CASE_SADDLE_A || code == CASE_SADDLE_B) && (zsum < iso4);
    push_item.row  = row;
    push_item.col  = col;
  end

  assign s_tready   = push_ready;
  assign push_valid = s_tvalid && inside_grid && code != CASE_NONE && code != CASE_ALL;

endmodule

/* rtl/msq_fifo.sv */
// Short queue of classified cells between the front end and the back end.
// Depends on msq_pkg for the cell type.
module msq_fifo import msq_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  cell_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output cell_t pop_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cell_t            mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;
  logic             do_push, do_pop;

  assign push_ready = count != (AW+1)'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule

/* rtl/msq_back.sv */
// Back end: a pipelined restoring divider, one quotient bit per stage for every
// cell edge, then the segment sequencer and the output register. Depends on msq_pkg.
module msq_back import msq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  cell_t             pop_item,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,
  output logic [USER_W-1:0] m_tuser,
  output logic              m_tlast
);

  localparam int NS = FRAC_BITS + 1;
  localparam int QW = FRAC_BITS + 1;
  localparam int CW = IDX_W + 1 + FRAC_BITS;
  localparam int SW = ((CW > COORD_W) ? CW : COORD_W) + 1;

  logic [3:0][DIV_W:0]   rem  [NS];
  logic [3:0][DIV_W-1:0] den  [NS];
  logic [3:0][QW-1:0]    quo  [NS];
  logic [CODE_W-1:0]     code [NS];
  logic                  flip [NS];
  logic [IDX_W-1:0]      row  [NS];
  logic [IDX_W-1:0]      col  [NS];
  logic                  v    [NS];
  logic                  en   [NS];
  logic                  take;

  logic [3:0][QW-1:0]    hq;
  logic [CODE_W-1:0]     hcode;
  logic                  hflip;
  logic [IDX_W-1:0]      hrow, hcol;
  logic                  hv, phase;
  logic                  out_load, seg_last, saddle, cut;
  edge_t                 e0, e1;
  logic [COORD_W-1:0]    sx, sy, ex, ey;

  assign pop_ready = en[0];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic [3:0][DIV_W:0]   r_in;
    logic [3:0][DIV_W-1:0] d_in;
    logic [3:0][QW-1:0]    q_in;
    logic [3:0][DIV_W:0]   r_out;
    logic [3:0][QW-1:0]    q_out;
    logic                  in_valid;
    logic                  move;

    if (i == 0) begin : g_src
      always_comb begin
        for (int k = 0; k < 4; k++) begin
          r_in[k] = (DIV_W+1)'(pop_item.num[k]);
          q_in[k] = '0;
        end
        d_in     = pop_item.den;
        in_valid = pop_valid;
      end
    end else begin : g_src
      assign r_in     = rem[i-1];
      assign d_in     = den[i-1];
      assign q_in     = quo[i-1];
      assign in_valid = v[i-1];
    end

    if (i == NS - 1) begin : g_mv
      assign move = v[i] && take;
    end else begin : g_mv
      assign move = v[i] && en[i+1];
    end
    assign en[i] = !v[i] || move;

    always_comb begin
      for (int k = 0; k < 4; k++) begin
        logic [DIV_W:0] rs;
        logic           ge;
        rs = (i == 0) ? r_in[k] : (r_in[k] << 1);
        ge = rs >= (DIV_W+1)'(d_in[k]);
        r_out[k] = ge ? rs - (DIV_W+1)'(d_in[k]) : rs;
        q_out[k] = {q_in[k][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en[i]) begin
        v[i] <= in_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en[i] && in_valid) begin
        rem[i] <= r_out;
        den[i] <= d_in;
        quo[i] <= q_out;
        if (i == 0) begin
          code[i] <= pop_item.code;
          flip[i] <= pop_item.flip;
          row[i]  <= pop_item.row;
          col[i]  <= pop_item.col;
        end else begin
          code[i] <= code[i-1];
          flip[i] <= flip[i-1];
          row[i]  <= row[i-1];
          col[i]  <= col[i-1];
        end
      end
    end
  end

  function automatic logic [2*COORD_W-1:0] edge_point(input edge_t e,
                                                      input logic [3:0][QW-1:0] q,
                                                      input logic [IDX_W-1:0] r,
                                                      input logic [IDX_W-1:0] c);
    logic [SW-1:0] bx, by, px, py;
    logic [SW-1:0] cmax;
    cmax = SW'({COORD_W{1'b1}});
    bx = SW'(c) + SW'(e == EDGE_R);
    by = SW'(r) + SW'(e == EDGE_B);
    px = (bx << FRAC_BITS) + ((e == EDGE_T || e == EDGE_B) ? SW'(q[e]) : '0);
    py = (by << FRAC_BITS) + ((e == EDGE_L || e == EDGE_R) ? SW'(q[e]) : '0);
    if (px > cmax) px = cmax;
    if (py > cmax) py = cmax;
    return {py[COORD_W-1:0], px[COORD_W-1:0]};
  endfunction

  always_comb begin
    saddle   = hcode == CASE_SADDLE_A || hcode == CASE_SADDLE_B;
    cut      = (hcode == CASE_SADDLE_A) ^ hflip;
    seg_last = phase || !saddle;
    if (saddle) begin
      e0 = phase ? EDGE_L : EDGE_R;
      e1 = (phase ^ cut) ? EDGE_B : EDGE_T;
    end else begin
      e0 = seg_first(hcode);
      e1 = seg_second(hcode);
    end
    {sy, sx} = edge_point(e0, hq, hrow, hcol);
    {ey, ex} = edge_point(e1, hq, hrow, hcol);
    out_load = hv && (!m_tvalid || m_tready);
    take     = !hv || (out_load && seg_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hv       <= 1'b0;
      phase    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (take) begin
        hv    <= v[NS-1];
        phase <= 1'b0;
      end else if (out_load) begin
        phase <= 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && v[NS-1]) begin
      hq    <= quo[NS-1];
      hcode <= code[NS-1];
      hflip <= flip[NS-1];
      hrow  <= row[NS-1];
      hcol  <= col[NS-1];
    end
    if (out_load) begin
      m_tdata <= {ey, ex, sy, sx};
      m_tuser <= {hflip, hcode};
      m_tlast <= seg_last;
    end
  end

endmodule

/* rtl/marching_squares_cell_segments.sv */
// Top level of the marching-squares cell segment generator.
// Instantiates msq_front, msq_fifo and msq_back; depends on msq_pkg.
//
// The slave stream carries one grid cell per transfer: four corner heights and
// the cell's row and column. The master stream carries one line segment per
// transfer; tlast marks the final segment of a cell, and tuser gives the case
// code and the saddle flip flag. The isoline is written through the cfg channel,
// which is always ready; the user must write it only while no cell is in flight,
// which the block does not enforce. Cells that lie outside the grid, or whose
// four corners all fall on the same side of the isoline, produce no transfer.
// A cell's first segment passes through the queue, FRAC_BITS + 1 divider
// stages (one quotient bit for every cell edge per stage) and the segment
// holder, after which it sits in the output register. A cell is taken every
// cycle while the queue is not full; the output register sends one segment per
// cycle while the master side is ready, and saddle cells send their two
// segments one after the other.
// When the master side stalls, the output register holds its segment, the
// divider stages and the four-entry queue fill, and then s_tready falls.
// Reset empties the queue, the stages and the output and sets the isoline to 0.
module marching_squares_cell_segments import msq_pkg::*; #(
  parameter int GRID_DIM  = GRID_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [H_W-1:0]    cfg_data,
  input  logic              s_tvalid,
  output logic              s_tready,
  // height_top_left, height_top_right, height_bottom_right, height_bottom_left,
  // cell_row, cell_col, then zero fill.
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // start_x, start_y, end_x, end_y.
  output logic [OUT_W-1:0]  m_tdata,
  // case_code, saddle_flipped.
  output logic [USER_W-1:0] m_tuser,
  output logic              m_tlast
);

  logic  push_valid, push_ready, pop_valid, pop_ready;
  cell_t push_item, pop_item;

  msq_front #(.GRID_DIM(GRID_DIM)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  msq_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  msq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
